/* sv/round_robin_tick_scheduler_defines.svh */
// assertion macros shared by the scheduler rtl
`ifndef ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* sv/rrts_pkg.sv */
`default_nettype none
package rrts_pkg;
  localparam int RRTS_SLOTS     = 64;
  localparam int RRTS_TIME_BITS = 16;
  localparam int FIELD_W        = 16;
  localparam int SLOT_W         = 6;
  localparam int QUANT_W        = 8;
  localparam int COUNT_W        = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'd1;

  localparam logic [FIELD_W-1:0] WAIT_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] task_id;
    logic [FIELD_W-1:0] total;
    logic [FIELD_W-1:0] rem;
    logic [FIELD_W-1:0] waits;
    logic               ready;
  } slot_rec_t;
endpackage
`default_nettype wire

/* sv/rrts_if.sv */
`default_nettype none
interface rrts_req_if import rrts_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_W-1:0]  slot;
  logic [FIELD_W-1:0] task_id;
  logic [FIELD_W-1:0] arrival;
  logic [FIELD_W-1:0] service;
  modport source (output valid, kind, slot, task_id, arrival, service, input ready);
  modport sink (input valid, kind, slot, task_id, arrival, service, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  running_slot;
  logic               idle;
  logic               finished;
  logic [FIELD_W-1:0] finished_id;
  logic [FIELD_W-1:0] finish_time;
  logic [FIELD_W-1:0] turnaround;
  logic [FIELD_W-1:0] service_total;
  logic               all_done;
  modport source (output valid, running_slot, idle, finished, finished_id, finish_time,
                  turnaround, service_total, all_done, input ready);
  modport sink (input valid, running_slot, idle, finished, finished_id, finish_time,
                turnaround, service_total, all_done, output ready);
endinterface
`default_nettype wire

/* sv/rrts_cell.sv */
`default_nettype none
module rrts_cell import rrts_pkg::*; #(
  parameter int TIME_BITS = RRTS_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 shift_en,
  input  wire slot_rec_t            rec_in,
  input  wire logic [TIME_BITS-1:0] arr_in,
  output slot_rec_t                 rec_out,
  output logic [TIME_BITS-1:0]      arr_out
);
  slot_rec_t            rec_r;
  logic [TIME_BITS-1:0] arr_r;

  // wait and ready have a defined reset, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.waits <= '0;
      rec_r.ready <= 1'b0;
    end else if (shift_en) begin
      rec_r.waits <= rec_in.waits;
      rec_r.ready <= rec_in.ready;
    end
    if (shift_en) begin
      rec_r.task_id <= rec_in.task_id;
      rec_r.total   <= rec_in.total;
      rec_r.rem     <= rec_in.rem;
      arr_r         <= arr_in;
    end
  end

  assign rec_out = rec_r;
  assign arr_out = arr_r;
endmodule
`default_nettype wire

/* sv/round_robin_tick_scheduler.sv */
// round robin tick scheduler
// in_chan carries requests: kind 0 loads a task slot (id, arrival, service),
// kind 1 is one scheduler tick. each tick gives exactly one response on
// out_chan (running slot, idle, finish data, all_done); loads give none.
// cfg_we/cfg_idx/cfg_data write quantum (index 0) and task_count (index 1);
// the user must do so only while the block is idle; the block itself does not enforce it.
// slot state lives in a ring of SLOTS cells that rotates one slot per cycle
// past a single head unit while a load or tick pass runs; a load is one pass.
// a tick is one pass for arrivals and selection, one pass for wait and work
// updates, then the response is written to the output register.
// a new request is taken once the previous one has left the ring, even while
// the last response still waits in the output register; if the receiver
// stalls, a following tick holds before its response until the register frees.
// reset (synchronous, rst_n low) clears waits, ready flags, the tick count and
// the slice state; quantum resets to 1, task_count to 0.
`default_nettype none
`include "round_robin_tick_scheduler_defines.svh"
module round_robin_tick_scheduler import rrts_pkg::*; #(
  parameter int SLOTS     = RRTS_SLOTS,
  parameter int TIME_BITS = RRTS_TIME_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rrts_req_if.sink                   in_chan,
  rrts_rsp_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]           st_r, st_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]    ld_slot_r;
  logic [FIELD_W-1:0]   ld_id_r, ld_arr_r, ld_svc_r;
  logic [IW-1:0]        best_r, best_nxt;
  logic [FIELD_W-1:0]   bw_r, bw_nxt;
  logic                 repl_r, repl_nxt;
  logic                 cok_r, cok_nxt;
  logic [IW-1:0]        chosen_r, chosen_nxt;
  logic [FIELD_W-1:0]   cw_r, cw_nxt;
  logic                 selecting_r, selecting_nxt;
  logic [QUANT_W-1:0]   slice_r, slice_nxt;
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_W-1:0]   done_r, done_nxt;
  logic [QUANT_W-1:0]   quantum_r;
  logic [COUNT_W-1:0]   tc_r;
  logic                 fhit_r, fhit_nxt;
  logic [FIELD_W-1:0]   fid_r, fid_nxt, ftot_r, ftot_nxt;
  logic [TIME_BITS-1:0] farr_r, farr_nxt;

  logic                 ov_r, ov_nxt;
  logic [SLOT_W-1:0]    o_slot_r, o_slot_nxt;
  logic                 o_idle_r, o_idle_nxt, o_fin_r, o_fin_nxt, o_all_r, o_all_nxt;
  logic [FIELD_W-1:0]   o_id_r, o_id_nxt, o_ft_r, o_ft_nxt;
  logic [FIELD_W-1:0]   o_ta_r, o_ta_nxt, o_tot_r, o_tot_nxt;

  slot_rec_t            rec [SLOTS];
  logic [TIME_BITS-1:0] arr [SLOTS];
  slot_rec_t            hrec;
  logic [TIME_BITS-1:0] harr;
  logic                 shift_en;

  logic                 accept, inn, rdy, run, load_hit, out_free;
  logic [IW-1:0]        chosen_new;
  logic [FIELD_W-1:0]   rem_dec;
  logic [QUANT_W-1:0]   slice_inc;
  logic [TIME_BITS-1:0] fin_t;

  assign shift_en = (st_r == S_LOAD) || (st_r == S_SCAN) || (st_r == S_UPD);

  for (genvar k = 0; k < SLOTS; k++) begin : g_ring
    if (k == SLOTS - 1) begin : g_tail
      rrts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .rec_in(hrec), .arr_in(harr), .rec_out(rec[k]), .arr_out(arr[k]));
    end else begin : g_mid
      rrts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .rec_in(rec[k+1]), .arr_in(arr[k+1]), .rec_out(rec[k]), .arr_out(arr[k]));
    end
  end

  assign in_chan.ready = (st_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !ov_r || out_chan.ready;
  assign inn           = int'(idx_r) < int'(tc_r);
  assign rdy           = rec[0].ready || (inn && (arr[0] == tick_r));
  assign run           = repl_r || cok_r;
  assign chosen_new    = run ? best_r : chosen_r;
  assign load_hit      = (int'(ld_slot_r) < SLOTS) && (int'(idx_r) == int'(ld_slot_r));
  assign rem_dec       = rec[0].rem - FIELD_W'(1);
  assign slice_inc     = slice_r + QUANT_W'(1);
  assign fin_t         = tick_r + TIME_BITS'(1);

  // head unit: one slot per cycle while the ring shifts
  always_comb begin
    hrec = rec[0];
    harr = arr[0];
    case (st_r)
      S_LOAD: begin
        if (load_hit) begin
          hrec.task_id = ld_id_r;
          hrec.total   = ld_svc_r;
          hrec.rem     = ld_svc_r;
          hrec.waits   = '0;
          hrec.ready   = 1'b0;
          harr         = TIME_BITS'(ld_arr_r);
        end
      end
      S_SCAN: hrec.ready = rdy;
      S_UPD: begin
        if (run && (idx_r == best_r)) begin
          hrec.waits = '0;
          hrec.rem   = rem_dec;
          if (rem_dec == '0) hrec.ready = 1'b0;
        end else if (inn && rec[0].ready && (rec[0].waits != WAIT_MAX)) begin
          hrec.waits = rec[0].waits + FIELD_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    bw_nxt        = bw_r;
    repl_nxt      = repl_r;
    cok_nxt       = cok_r;
    chosen_nxt    = chosen_r;
    cw_nxt        = cw_r;
    selecting_nxt = selecting_r;
    slice_nxt     = slice_r;
    tick_nxt      = tick_r;
    done_nxt      = done_r;
    fhit_nxt      = fhit_r;
    fid_nxt       = fid_r;
    ftot_nxt      = ftot_r;
    farr_nxt      = farr_r;
    ov_nxt        = ov_r && !out_chan.ready;
    o_slot_nxt    = o_slot_r;
    o_idle_nxt    = o_idle_r;
    o_fin_nxt     = o_fin_r;
    o_all_nxt     = o_all_r;
    o_id_nxt      = o_id_r;
    o_ft_nxt      = o_ft_r;
    o_ta_nxt      = o_ta_r;
    o_tot_nxt     = o_tot_r;
    if (shift_en) begin
      idx_nxt = (idx_r == LAST) ? '0 : idx_r + IW'(1);
    end
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.kind) begin
            st_nxt   = S_SCAN;
            best_nxt = chosen_r;
            bw_nxt   = cw_r;
            repl_nxt = 1'b0;
            cok_nxt  = 1'b0;
          end else begin
            st_nxt = S_LOAD;
            if ((int'(in_chan.slot) < SLOTS) && (int'(in_chan.slot) == int'(chosen_r))) begin
              cw_nxt = '0;
            end
          end
        end
      end
      S_LOAD: begin
        if (idx_r == LAST) st_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (idx_r == chosen_r) cok_nxt = inn && rdy && (rec[0].rem != '0);
        if (selecting_r && inn && rdy && (rec[0].rem != '0) && (rec[0].waits >= bw_r)) begin
          best_nxt = idx_r;
          bw_nxt   = rec[0].waits;
          repl_nxt = 1'b1;
        end
        if (idx_r == LAST) begin
          st_nxt   = S_UPD;
          fhit_nxt = 1'b0;
        end
      end
      S_UPD: begin
        if (idx_r == chosen_new) cw_nxt = hrec.waits;
        if (run && (idx_r == best_r) && (rem_dec == '0)) begin
          fhit_nxt = 1'b1;
          fid_nxt  = rec[0].task_id;
          ftot_nxt = rec[0].total;
          farr_nxt = arr[0];
        end
        if (idx_r == LAST) st_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          st_nxt     = S_IDLE;
          ov_nxt     = 1'b1;
          o_slot_nxt = '0;
          o_idle_nxt = !run;
          o_fin_nxt  = 1'b0;
          o_id_nxt   = '0;
          o_ft_nxt   = '0;
          o_ta_nxt   = '0;
          o_tot_nxt  = '0;
          if (!run) begin
            slice_nxt     = '0;
            selecting_nxt = 1'b1;
          end else begin
            chosen_nxt = best_r;
            o_slot_nxt = SLOT_W'(best_r);
            if (!fhit_r && (slice_inc != quantum_r)) begin
              selecting_nxt = 1'b0;
              slice_nxt     = slice_inc;
            end else begin
              selecting_nxt = 1'b1;
              slice_nxt     = '0;
            end
            if (fhit_r) begin
              done_nxt  = done_r + COUNT_W'(1);
              o_fin_nxt = 1'b1;
              o_id_nxt  = fid_r;
              o_ft_nxt  = FIELD_W'(fin_t);
              o_ta_nxt  = FIELD_W'(fin_t - farr_r);
              o_tot_nxt = ftot_r;
            end
          end
          o_all_nxt = (done_nxt == tc_r);
          tick_nxt  = fin_t;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      idx_r       <= '0;
      chosen_r    <= '0;
      cw_r        <= '0;
      selecting_r <= 1'b1;
      slice_r     <= '0;
      tick_r      <= '0;
      done_r      <= '0;
      quantum_r   <= QUANT_W'(1);
      tc_r        <= '0;
      ov_r        <= 1'b0;
      repl_r      <= 1'b0;
      cok_r       <= 1'b0;
      fhit_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      chosen_r    <= chosen_nxt;
      cw_r        <= cw_nxt;
      selecting_r <= selecting_nxt;
      slice_r     <= slice_nxt;
      tick_r      <= tick_nxt;
      done_r      <= done_nxt;
      ov_r        <= ov_nxt;
      repl_r      <= repl_nxt;
      cok_r       <= cok_nxt;
      fhit_r      <= fhit_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_QUANTUM:    quantum_r <= cfg_data[QUANT_W-1:0];
          CFG_TASK_COUNT: tc_r      <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_slot_r <= in_chan.slot;
      ld_id_r   <= in_chan.task_id;
      ld_arr_r  <= in_chan.arrival;
      ld_svc_r  <= in_chan.service;
    end
    best_r   <= best_nxt;
    bw_r     <= bw_nxt;
    fid_r    <= fid_nxt;
    ftot_r   <= ftot_nxt;
    farr_r   <= farr_nxt;
    o_slot_r <= o_slot_nxt;
    o_idle_r <= o_idle_nxt;
    o_fin_r  <= o_fin_nxt;
    o_all_r  <= o_all_nxt;
    o_id_r   <= o_id_nxt;
    o_ft_r   <= o_ft_nxt;
    o_ta_r   <= o_ta_nxt;
    o_tot_r  <= o_tot_nxt;
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.running_slot  = o_slot_r;
  assign out_chan.idle          = o_idle_r;
  assign out_chan.finished      = o_fin_r;
  assign out_chan.finished_id   = o_id_r;
  assign out_chan.finish_time   = o_ft_r;
  assign out_chan.turnaround    = o_ta_r;
  assign out_chan.service_total = o_tot_r;
  assign out_chan.all_done      = o_all_r;

  `RRTS_ASSERT(a_rsp_from_fin, $rose(ov_r) |-> ($past(st_r) == S_FIN), "response outside fin")
  `RRTS_ASSERT(a_idle_no_fin, (ov_r && o_idle_r) |-> !o_fin_r, "idle response finished")
  `RRTS_ASSERT(a_idx_home, (st_r == S_IDLE) |-> (idx_r == '0), "ring not aligned at idle")
  `RRTS_ASSERT_NEXT(a_done_step, (st_r == S_FIN) && out_free && fhit_r && run, o_fin_r,
                    "finish lost")
endmodule
`default_nettype wire

/* verif/round_robin_tick_scheduler_tb.sv */
`timescale 1ns / 1ps
module round_robin_tick_scheduler_tb;
  import rrts_pkg::*;

  localparam int NSLOT = RRTS_SLOTS;
  localparam int TICK_LAT = 2 * NSLOT + 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1400;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0]  running_slot;
    logic               idle;
    logic               finished;
    logic [FIELD_W-1:0] finished_id;
    logic [FIELD_W-1:0] finish_time;
    logic [FIELD_W-1:0] turnaround;
    logic [FIELD_W-1:0] service_total;
    logic               all_done;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_QUANTUM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rrts_req_if req_if();
  rrts_rsp_if rsp_if();

  round_robin_tick_scheduler u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(req_if),
    .out_chan(rsp_if),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  logic [FIELD_W-1:0] m_id [NSLOT];
  logic [FIELD_W-1:0] m_arr [NSLOT];
  logic [FIELD_W-1:0] m_total [NSLOT];
  logic [FIELD_W-1:0] m_rem [NSLOT];
  logic [FIELD_W-1:0] m_wait [NSLOT];
  logic               m_rdy [NSLOT];
  logic [SLOT_W-1:0]  m_chosen = '0;
  logic               m_selecting = 1'b1;
  logic [7:0]         m_slice = '0;
  logic [FIELD_W-1:0] m_tick = '0;
  logic [6:0]         m_done = '0;
  logic [7:0]         m_quantum = 8'd1;
  logic [6:0]         m_task_count = '0;

  tick_result_t expected_ticks[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  bit no_gaps = 0;
  bit no_stalls = 0;
  int stall_left = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = KIND_LOAD;
    req_if.slot = '0;
    req_if.task_id = '0;
    req_if.arrival = '0;
    req_if.service = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      m_id[i] = '0; m_arr[i] = '0; m_total[i] = '0; m_rem[i] = '0;
      m_wait[i] = '0; m_rdy[i] = 1'b0;
    end
  end

  function automatic tick_result_t schedule_tick();
    tick_result_t r;
    int n;
    int best;
    logic [FIELD_W-1:0] bw;
    logic [FIELD_W-1:0] fin;
    r = '0;
    n = (int'(m_task_count) < NSLOT) ? int'(m_task_count) : NSLOT;
    for (int i = 0; i < n; i++)
      if (m_arr[i] == m_tick) m_rdy[i] = 1'b1;
    best = int'(m_chosen);
    if (m_selecting) begin
      bw = m_wait[best];
      for (int i = 0; i < n; i++)
        if (m_rdy[i] && m_rem[i] != 0 && m_wait[i] >= bw) begin
          best = i;
          bw = m_wait[i];
        end
    end
    if (!(best < n && m_rdy[best] && m_rem[best] != 0)) begin
      for (int i = 0; i < n; i++)
        if (m_rdy[i] && m_wait[i] != WAIT_MAX) m_wait[i]++;
      m_slice = '0;
      m_selecting = 1'b1;
      r.idle = 1'b1;
    end else begin
      m_chosen = SLOT_W'(best);
      m_wait[best] = '0;
      m_rem[best]--;
      m_slice++;
      for (int i = 0; i < n; i++)
        if (i != best && m_rdy[i] && m_wait[i] != WAIT_MAX) m_wait[i]++;
      r.running_slot = SLOT_W'(best);
      if (m_rem[best] != 0 && m_slice != m_quantum) begin
        m_selecting = 1'b0;
      end else begin
        if (m_rem[best] == 0) begin
          fin = m_tick + 1'b1;
          m_rdy[best] = 1'b0;
          m_done++;
          r.finished = 1'b1;
          r.finished_id = m_id[best];
          r.finish_time = fin;
          r.turnaround = fin - m_arr[best];
          r.service_total = m_total[best];
        end
        m_slice = '0;
        m_selecting = 1'b1;
      end
    end
    r.all_done = (m_done == m_task_count);
    m_tick++;
    return r;
  endfunction

  task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                              input logic [FIELD_W-1:0] id, input logic [FIELD_W-1:0] arr,
                              input logic [FIELD_W-1:0] svc);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.slot <= slot;
    req_if.task_id <= id;
    req_if.arrival <= arr;
    req_if.service <= svc;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_TICK) begin
      expected_ticks.push_back(schedule_tick());
    end else begin
      m_id[slot] = id; m_arr[slot] = arr; m_total[slot] = svc; m_rem[slot] = svc;
      m_wait[slot] = '0; m_rdy[slot] = 1'b0;
    end
  endtask

  task automatic load_slot(input int slot, input logic [FIELD_W-1:0] id,
                           input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] svc);
    send_request(KIND_LOAD, SLOT_W'(slot), id, arr, svc);
  endtask

  task automatic run_ticks(input int count);
    repeat (count)
      send_request(KIND_TICK, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                   FIELD_W'($urandom));
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (TICK_LAT) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] quantum, input logic [6:0] task_count);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_QUANTUM;
    cfg_data <= quantum;
    @(posedge clk);
    m_quantum = quantum;
    cfg_idx <= CFG_TASK_COUNT;
    cfg_data <= CFG_DATA_W'(task_count);
    @(posedge clk);
    m_task_count = task_count;
    cfg_we <= 1'b0;
  endtask

  task automatic test_special_cases();
    set_config(8'd2, 7'd4);
    load_slot(0, 16'h0000, m_tick, 16'd3);
    load_slot(1, 16'hffff, m_tick, 16'd1);
    load_slot(2, 16'h1234, m_tick - 1'b1, 16'd2);
    load_slot(3, 16'h00ff, m_tick + 1'b1, 16'd0);
    load_slot(63, 16'ha5a5, 16'hffff, 16'hffff);
    run_ticks(8);
    // chosen slot dropped mid slice by lowering task_count
    set_config(8'd255, 7'd2);
    load_slot(0, 16'h5a5a, m_tick, 16'd4);
    load_slot(1, 16'hbeef, m_tick, 16'd20);
    run_ticks(4);
    set_config(8'd255, 7'd1);
    run_ticks(2);
  endtask

  task automatic test_random_phase(input logic [7:0] quantum, input logic [6:0] task_count);
    int n;
    int budget;
    int max_svc;
    int offset;
    int nticks;
    logic [FIELD_W-1:0] svc;
    logic [FIELD_W-1:0] arr;
    no_gaps = ($urandom_range(0, 4) == 0);
    no_stalls = ($urandom_range(0, 4) == 0);
    set_config(quantum, task_count);
    n = (int'(task_count) < NSLOT) ? int'(task_count) : NSLOT;
    max_svc = ($urandom_range(0, 3) == 0) ? 30 : 5;
    budget = 12;
    for (int i = 0; i < n; i++) begin
      offset = int'($urandom_range(0, 8));
      arr = FIELD_W'(int'(m_tick) + offset);
      svc = FIELD_W'($urandom_range(1, max_svc));
      case ($urandom_range(0, 15))
        0: arr = FIELD_W'(int'(m_tick) - int'($urandom_range(1, 5)));
        1: svc = '0;
        2: arr = FIELD_W'($urandom);
        3: if (n <= 8) svc = FIELD_W'($urandom);
        default: budget += int'(svc);
      endcase
      load_slot(i, FIELD_W'($urandom), arr, svc);
    end
    nticks = (budget > 300) ? 300 : budget;
    for (int t = 0; t < nticks; t++) begin
      if ($urandom_range(0, 29) == 0)
        load_slot(int'($urandom_range(0, NSLOT - 1)), FIELD_W'($urandom),
                  FIELD_W'(int'(m_tick) + int'($urandom_range(0, 3))),
                  FIELD_W'($urandom_range(0, 6)));
      run_ticks(1);
    end
  endtask

  task automatic test_random();
    test_random_phase(8'd0, 7'd64);
    test_random_phase(8'd255, 7'd0);
    test_random_phase(8'd1, 7'd3);
    while (items_sent < ITEM_TARGET)
      test_random_phase(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(1, 4)),
                        ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 64))
                                                     : 7'($urandom_range(1, 8)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_random();
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_ticks.size() == 0) begin
        flag_mismatch("unexpected response", '0, '0);
      end else begin
        want = expected_ticks.pop_front();
        if (rsp_if.running_slot !== want.running_slot)
          flag_mismatch("running_slot", FIELD_W'(rsp_if.running_slot),
                        FIELD_W'(want.running_slot));
        if (rsp_if.idle !== want.idle)
          flag_mismatch("idle", FIELD_W'(rsp_if.idle), FIELD_W'(want.idle));
        if (rsp_if.finished !== want.finished)
          flag_mismatch("finished", FIELD_W'(rsp_if.finished), FIELD_W'(want.finished));
        if (rsp_if.finished_id !== want.finished_id)
          flag_mismatch("finished_id", rsp_if.finished_id, want.finished_id);
        if (rsp_if.finish_time !== want.finish_time)
          flag_mismatch("finish_time", rsp_if.finish_time, want.finish_time);
        if (rsp_if.turnaround !== want.turnaround)
          flag_mismatch("turnaround", rsp_if.turnaround, want.turnaround);
        if (rsp_if.service_total !== want.service_total)
          flag_mismatch("service_total", rsp_if.service_total, want.service_total);
        if (rsp_if.all_done !== want.all_done)
          flag_mismatch("all_done", FIELD_W'(rsp_if.all_done), FIELD_W'(want.all_done));
      end
    end
  end

  always @(posedge clk) begin
    int left;
    left = stall_left;
    if (rsp_if.valid && rsp_if.ready) left = no_stalls ? 0 : int'($urandom_range(0, 7));
    else if (left > 0) left--;
    stall_left <= left;
    rsp_if.ready <= rst_n && (left == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end
endmodule

/* sim.f */
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_if.sv
sv/rrts_cell.sv
sv/round_robin_tick_scheduler.sv
verif/round_robin_tick_scheduler_tb.sv
